### src/arv_pkg.sv
// Shared types, constants and CORDIC angle table for the arc ring strip block.
package arv_pkg;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        inner_radius;
        logic [15:0]        outer_radius;
        logic [16:0]        progress;
        logic [6:0]         max_vertices;
    } arv_in_t;

    typedef struct packed {
        logic signed [15:0] inner_x;
        logic signed [15:0] inner_y;
        logic signed [15:0] outer_x;
        logic signed [15:0] outer_y;
        logic [5:0]         pair_index;
        logic               last;
    } arv_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       cordic_init;
        logic       cordic_step;
        logic       mul;
        logic       place;
        logic       emit;
        logic       advance;
        logic [3:0] idx;
    } arv_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic last_pair;
        logic out_free;
    } arv_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_DIV, ST_INIT, ST_ROT, ST_MUL, ST_PLACE, ST_EMIT
    } arv_state_t;

    localparam int unsigned CORDIC_ITERS = 16;
    localparam int unsigned DIV_CYCLES   = 2;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [16:0] ONE_TURN = 17'd65536;
    localparam logic [6:0]  MIN_CAP  = 7'd4;

    function automatic logic signed [32:0] atan_turn(input logic [3:0] i);
        logic signed [32:0] a;
        case (i)
            4'd0:    a = 33'sd536870912;
            4'd1:    a = 33'sd316933406;
            4'd2:    a = 33'sd167458907;
            4'd3:    a = 33'sd85004756;
            4'd4:    a = 33'sd42667331;
            4'd5:    a = 33'sd21354465;
            4'd6:    a = 33'sd10679838;
            4'd7:    a = 33'sd5340245;
            4'd8:    a = 33'sd2670163;
            4'd9:    a = 33'sd1335087;
            4'd10:   a = 33'sd667544;
            4'd11:   a = 33'sd333772;
            4'd12:   a = 33'sd166886;
            4'd13:   a = 33'sd83443;
            4'd14:   a = 33'sd41721;
            default: a = 33'sd20861;
        endcase
        return a;
    endfunction

endpackage

### src/arc_ring_strip_vertices_top.sv
// Top level of the arc ring triangle-strip vertex generator.
// Takes one ring request and emits min(STEPS+1, max_vertices/2) inner/outer vertex pairs
// for a clockwise arc from twelve o'clock, or nothing when progress is zero or capacity is
// under four. One request at a time: it is accepted, checked, then constant multiplies
// form the per-step phase increment and its remainder. Each pair then takes a setup,
// 16 iterations of the shared CORDIC rotator, 4 multiply-and-place passes through one
// shared multiplier and an output load. The output load waits while the previous word is
// still unaccepted. A finished word waits in the output register without blocking the next
// request's acceptance.
module arc_ring_strip_vertices_top
    import arv_pkg::*;
#(
    parameter int STEPS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  arv_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output arv_out_t m_data
);

    arv_cmd_t cmd;
    arv_sts_t sts;

    arv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    arv_dp #(
        .STEPS (STEPS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### src/arv_ctrl.sv
// Controller state machine: sequences division, CORDIC, placement and output.
module arv_ctrl
    import arv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  arv_sts_t sts,
    output arv_cmd_t cmd
);

    arv_state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    // Hold state and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Pick next state and issue commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg[3:0];
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cnt_next   = '0;
                state_next = sts.empty ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_CYCLES - 1)) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = ST_ROT;
            end
            ST_ROT: begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_ITERS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_PLACE;
            end
            ST_PLACE: begin
                cmd.place = 1'b1;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.last_pair) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_INIT;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### src/arv_dp.sv
// Datapath: phase divider and accumulator, CORDIC rotator, vertex placement, output word.
module arv_dp
    import arv_pkg::*;
#(
    parameter int STEPS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  arv_in_t  s_data,
    input  arv_cmd_t cmd,
    output arv_sts_t sts,
    output logic     m_valid,
    input  logic     m_ready,
    output arv_out_t m_data
);

    localparam logic [6:0]  STEPS_W   = 7'(STEPS);
    localparam logic [6:0]  PAIRS_MAX = 7'(STEPS + 1);
    // 2^16 = STEP_Q0*STEPS + STEP_R0; STEP_M = ceil(2^28/STEPS) for the small quotient
    localparam logic [15:0] STEP_Q0   = 16'(65536 / STEPS);
    localparam logic [5:0]  STEP_R0   = 6'(65536 % STEPS);
    localparam logic [26:0] STEP_M    = 27'((268435456 + STEPS - 1) / STEPS);
    localparam logic [21:0] STEPS_22  = 22'(STEPS);

    arv_in_t            req_reg;
    logic [31:0]        div_reg;
    logic [16:0]        pc_reg;
    logic [21:0]        ny_reg;
    logic [19:0]        nt_reg;
    logic [5:0]         rem_reg;
    logic [5:0]         racc_reg;
    logic [31:0]        phase_reg;
    logic [5:0]         s_reg;
    logic [6:0]         pairs_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic signed [50:0] prod_reg;
    arv_out_t           work_reg;
    arv_out_t           out_reg;
    logic               m_valid_reg;

    logic [16:0]        p_clamp;
    logic [47:0]        ny_prod;
    logic [21:0]        div_rem;
    logic [31:0]        div_quot;
    logic [6:0]         racc_sum;
    logic signed [33:0] dx, dy;
    logic signed [33:0] sn, ncs;
    logic [15:0]        rad;
    logic signed [33:0] trig;
    logic signed [50:0] rounded;
    logic signed [20:0] off;
    logic signed [21:0] pos;
    logic signed [15:0] centre;
    logic signed [15:0] pos_sat;
    logic [6:0]         half_cap;

    assign p_clamp  = (s_data.progress > ONE_TURN) ? ONE_TURN : s_data.progress;
    assign half_cap = {1'b0, s_data.max_vertices[6:1]};
    assign racc_sum = {1'b0, racc_reg} + {1'b0, rem_reg};
    assign dx       = y_reg >>> cmd.idx;
    assign dy       = x_reg >>> cmd.idx;

    // Split p*2^16/STEPS into p*STEP_Q0 plus the quotient of p*STEP_R0 by STEPS
    assign ny_prod  = 48'(ny_reg) * 48'(STEP_M);
    assign div_rem  = ny_reg - 22'(nt_reg) * STEPS_22;
    assign div_quot = 32'(pc_reg) * 32'(STEP_Q0) + 32'(nt_reg);

    // Map the first-quadrant rotation to the phase quadrant
    always_comb begin
        case (phase_reg[31:30])
            2'd0:    begin ncs = -x_reg; sn = y_reg;  end
            2'd1:    begin ncs = y_reg;  sn = x_reg;  end
            2'd2:    begin ncs = x_reg;  sn = -y_reg; end
            default: begin ncs = -y_reg; sn = -x_reg; end
        endcase
    end

    // Select radius and trig term for the field in work
    assign rad     = cmd.idx[1] ? req_reg.outer_radius : req_reg.inner_radius;
    assign trig    = cmd.idx[0] ? ncs : sn;
    assign centre  = cmd.idx[0] ? req_reg.center_y : req_reg.center_x;
    assign rounded = (prod_reg + 51'sd536870912) >>> 30;
    assign off     = rounded[20:0];
    assign pos     = 22'(centre) + 22'(off);

    // Saturate the placed coordinate to 16 bits
    always_comb begin
        if (pos > 22'sd32767) begin
            pos_sat = 16'sh7fff;
        end else if (pos < -22'sd32768) begin
            pos_sat = 16'sh8000;
        end else begin
            pos_sat = pos[15:0];
        end
    end

    assign sts.empty     = (req_reg.progress == '0) || (req_reg.max_vertices < MIN_CAP);
    assign sts.last_pair = ({1'b0, s_reg} + 7'd1) == pairs_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_data;
            pc_reg    <= p_clamp;
            ny_reg    <= 22'(23'(p_clamp) * 23'(STEP_R0));
            rem_reg   <= '0;
            racc_reg  <= '0;
            phase_reg <= '0;
            s_reg     <= '0;
            pairs_reg <= (half_cap < PAIRS_MAX) ? half_cap : PAIRS_MAX;
        end
        // Form the per-step phase increment and its remainder
        if (cmd.div_step) begin
            if (!cmd.idx[0]) begin
                nt_reg <= ny_prod[47:28];
            end else begin
                rem_reg <= div_rem[5:0];
                div_reg <= div_quot;
            end
        end
        if (cmd.cordic_init) begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= {3'b0, phase_reg[29:0]};
        end
        // Rotate one CORDIC iteration
        if (cmd.cordic_step) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_turn(cmd.idx);
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_turn(cmd.idx);
            end
        end
        if (cmd.mul) begin
            prod_reg <= 51'($signed({1'b0, rad}) * trig);
        end
        if (cmd.place) begin
            case (cmd.idx[1:0])
                2'd0:    work_reg.inner_x <= pos_sat;
                2'd1:    work_reg.inner_y <= pos_sat;
                2'd2:    work_reg.outer_x <= pos_sat;
                default: work_reg.outer_y <= pos_sat;
            endcase
            work_reg.pair_index <= s_reg;
            work_reg.last       <= sts.last_pair;
        end
        if (cmd.emit) begin
            out_reg <= work_reg;
        end
        // Advance phase by the quotient, carrying the remainder
        if (cmd.advance) begin
            s_reg <= s_reg + 6'd1;
            if (racc_sum >= STEPS_W) begin
                racc_reg  <= 6'(racc_sum - STEPS_W);
                phase_reg <= phase_reg + div_reg + 32'd1;
            end else begin
                racc_reg  <= racc_sum[5:0];
                phase_reg <= phase_reg + div_reg;
            end
        end
    end

    // Hold output valid until the word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
